// File: rtl/rmth_pkg.sv
// rmth_pkg: types and constants for the running median two-heap block
// no dependencies
`default_nettype none
package rmth_pkg;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TOPS,
      ST_PUSH_RD,
      ST_PUSH_CMP,
      ST_POP_INIT,
      ST_POP_LOAD,
      ST_POP_RD,
      ST_POP_CMP,
      ST_MOVE,
      ST_FETCH,
      ST_FORM,
      ST_RESULT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture incoming beat
      logic tops;      // heap tops on read data, note overflow
      logic push_new;  // write sample at tail of its heap
      logic push_rd;   // read parent
      logic push_step; // compare with parent, move hole up or settle
      logic pop_init;  // shrink larger heap, read root and tail
      logic pop_load;  // keep old top, tail becomes moving value
      logic pop_rd;    // read children
      logic pop_step;  // compare with children, move hole down or settle
      logic move;      // write old top at tail of the other heap
      logic form;      // form result beat from both tops
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic full;       // store is at capacity
      logic push_done;  // sift-up finished
      logic pop_done;   // sift-down finished
      logic need_pop;   // heaps out of balance after insert
   } status_type;

endpackage
`default_nettype wire

// File: rtl/rmth_if.sv
// rmth_if: valid/ready channel carrying a packed payload
// no dependencies
`default_nettype none
interface rmth_if #(parameter int W = 16) (input wire logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rmth_ctrl.sv
// rmth_ctrl: sequencer for insert and rebalance
// depends on rmth_pkg
`default_nettype none
module rmth_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   input  wire rmth_pkg::status_type stat,
   output rmth_pkg::cmd_type         cmd
);
   import rmth_pkg::*;

   state_type state_ff, state_in;
   logic      rebal_ff, rebal_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rebal_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rebal_ff <= rebal_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      rebal_in = rebal_ff;
      unique case (state_ff)
         ST_IDLE: if (in_valid) state_in = ST_TOPS;
         ST_TOPS: begin
            rebal_in = 1'b0;
            state_in = stat.full ? ST_FETCH : ST_PUSH_RD;
         end
         ST_PUSH_RD: state_in = ST_PUSH_CMP;
         ST_PUSH_CMP: begin
            if (stat.push_done) begin
               if (!rebal_ff && stat.need_pop) state_in = ST_POP_INIT;
               else state_in = ST_FETCH;
            end else begin
               state_in = ST_PUSH_RD;
            end
         end
         ST_POP_INIT: begin
            rebal_in = 1'b1;
            state_in = ST_POP_LOAD;
         end
         ST_POP_LOAD: state_in = ST_POP_RD;
         ST_POP_RD: state_in = ST_POP_CMP;
         ST_POP_CMP: state_in = stat.pop_done ? ST_MOVE : ST_POP_RD;
         ST_MOVE: state_in = ST_PUSH_RD;
         ST_FETCH: state_in = ST_FORM;
         ST_FORM: state_in = ST_RESULT;
         ST_RESULT: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         ST_TOPS: begin
            cmd.tops     = 1'b1;
            cmd.push_new = !stat.full;
         end
         ST_PUSH_RD: cmd.push_rd = 1'b1;
         ST_PUSH_CMP: cmd.push_step = 1'b1;
         ST_POP_INIT: cmd.pop_init = 1'b1;
         ST_POP_LOAD: cmd.pop_load = 1'b1;
         ST_POP_RD: cmd.pop_rd = 1'b1;
         ST_POP_CMP: cmd.pop_step = 1'b1;
         ST_MOVE: cmd.move = 1'b1;
         ST_FETCH: ;
         ST_FORM: cmd.form = 1'b1;
         ST_RESULT: out_valid = 1'b1;
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/rmth_dp.sv
// rmth_dp: heap memories, indices and comparators
// depends on rmth_pkg
`default_nettype none
module rmth_dp #(
   parameter int CAPACITY     = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rmth_pkg::cmd_type       cmd,
   output rmth_pkg::status_type         stat,
   input  wire logic [SAMPLE_WIDTH-1:0] sample,
   output logic [SAMPLE_WIDTH:0]        median_x2,
   output logic [10:0]                  count,
   output logic                         overflow
);
   import rmth_pkg::*;

   localparam int DEPTH = CAPACITY / 2 + 1;
   localparam int IW    = $clog2(DEPTH);      // heap address
   localparam int SZW   = $clog2(DEPTH + 1);  // heap size
   localparam int CHW   = IW + 2;             // child index, never wraps
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int SW    = SAMPLE_WIDTH;

   // heap stores, one per heap, one write and two read ports each
   logic [SW-1:0] lo_mem [DEPTH];
   logic [SW-1:0] up_mem [DEPTH];

   logic [SZW-1:0] lo_size_ff, lo_size_in, up_size_ff, up_size_in;
   logic           heap_ff, heap_in;   // 1: lower (max) heap selected
   logic [IW-1:0]  idx_ff, idx_in;     // hole being sifted
   logic [SZW-1:0] lim_ff, lim_in;     // size bound for sift-down
   logic [SW-1:0]  val_ff, val_in;     // value looking for its place
   logic [SW-1:0]  x_ff, pop_top_ff;
   logic [SW-1:0]  lo_qa_ff, lo_qb_ff, up_qa_ff, up_qb_ff;
   logic           ovf_ff;
   logic [SW:0]    med_ff, med_in;
   logic [CW-1:0]  cnt_ff;

   logic [SW-1:0]  q_a, q_b, lo_top, up_top;
   logic [IW-1:0]  parent;
   logic [CHW-1:0] lchild, rchild, lim_ext;
   logic           l_ok, r_ok, l_win, r_win, to_lo, from_lo;
   logic [SZW-1:0] from_size;
   logic [CW:0]    held;
   logic           wr_en, wr_lo;
   logic [IW-1:0]  wr_addr, rd_addr_a, rd_addr_b;
   logic [SW-1:0]  wr_data;

   // ordering: a goes ahead of b in the selected heap
   function automatic logic precedes(input logic mx, input logic [SW-1:0] a,
                                     input logic [SW-1:0] b);
      precedes = mx ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
   endfunction

   // registered read data of the selected heap
   assign q_a    = heap_ff ? lo_qa_ff : up_qa_ff;
   assign q_b    = heap_ff ? lo_qb_ff : up_qb_ff;
   assign lo_top = lo_qa_ff;
   assign up_top = up_qa_ff;

   assign parent  = (idx_ff - IW'(1)) >> 1;
   assign lchild  = {1'b0, idx_ff, 1'b1};
   assign rchild  = lchild + CHW'(1);
   assign lim_ext = CHW'(lim_ff);
   assign held    = (CW + 1)'(lo_size_ff) + (CW + 1)'(up_size_ff);

   // placement of a new sample, ties to the lower heap
   assign to_lo     = (lo_size_ff == '0) || !precedes(1'b1, x_ff, lo_top);
   assign from_lo   = lo_size_ff > up_size_ff;
   assign from_size = from_lo ? lo_size_ff : up_size_ff;

   // sift-down child choice
   assign l_ok  = lchild < lim_ext;
   assign r_ok  = rchild < lim_ext;
   assign l_win = l_ok && precedes(heap_ff, q_a, val_ff);
   assign r_win = r_ok && precedes(heap_ff, q_b, l_win ? q_a : val_ff);

   assign stat.full      = held >= (CW + 1)'(CAPACITY);
   assign stat.push_done = (idx_ff == '0) || !precedes(heap_ff, val_ff, q_a);
   assign stat.pop_done  = !l_win && !r_win;
   assign stat.need_pop  = (lo_size_ff > up_size_ff + SZW'(1)) || (up_size_ff > lo_size_ff);

   // heap indices, sizes and memory port control
   always_comb begin
      lo_size_in = lo_size_ff;
      up_size_in = up_size_ff;
      heap_in    = heap_ff;
      idx_in     = idx_ff;
      lim_in     = lim_ff;
      val_in     = val_ff;
      wr_en      = 1'b0;
      wr_lo      = heap_ff;
      wr_addr    = idx_ff;
      wr_data    = val_ff;
      rd_addr_a  = '0;
      rd_addr_b  = '0;
      // new sample at the tail of its heap
      if (cmd.push_new) begin
         heap_in = to_lo;
         val_in  = x_ff;
         wr_en   = 1'b1;
         wr_lo   = to_lo;
         wr_data = x_ff;
         if (to_lo) begin
            idx_in     = IW'(lo_size_ff);
            wr_addr    = IW'(lo_size_ff);
            lo_size_in = lo_size_ff + SZW'(1);
         end else begin
            idx_in     = IW'(up_size_ff);
            wr_addr    = IW'(up_size_ff);
            up_size_in = up_size_ff + SZW'(1);
         end
      end
      // old top of one heap goes to the tail of the other
      if (cmd.move) begin
         heap_in = !heap_ff;
         val_in  = pop_top_ff;
         wr_en   = 1'b1;
         wr_lo   = !heap_ff;
         wr_data = pop_top_ff;
         if (!heap_ff) begin
            idx_in     = IW'(lo_size_ff);
            wr_addr    = IW'(lo_size_ff);
            lo_size_in = lo_size_ff + SZW'(1);
         end else begin
            idx_in     = IW'(up_size_ff);
            wr_addr    = IW'(up_size_ff);
            up_size_in = up_size_ff + SZW'(1);
         end
      end
      if (cmd.push_rd) rd_addr_a = parent;
      // sift-up: parent drops into the hole, or the value settles
      if (cmd.push_step) begin
         wr_en = 1'b1;
         if (!stat.push_done) begin
            wr_data = q_a;
            idx_in  = parent;
         end
      end
      // pop from the larger heap: root and tail are read together
      if (cmd.pop_init) begin
         heap_in   = from_lo;
         idx_in    = '0;
         lim_in    = from_size - SZW'(1);
         rd_addr_b = IW'(from_size - SZW'(1));
         if (from_lo) lo_size_in = lo_size_ff - SZW'(1);
         else up_size_in = up_size_ff - SZW'(1);
      end
      if (cmd.pop_load) val_in = q_b;
      if (cmd.pop_rd) begin
         rd_addr_a = l_ok ? lchild[IW-1:0] : '0;
         rd_addr_b = r_ok ? rchild[IW-1:0] : '0;
      end
      // sift-down: winning child rises into the hole, or the value settles
      if (cmd.pop_step) begin
         wr_en = 1'b1;
         if (!stat.pop_done) begin
            wr_data = r_win ? q_b : q_a;
            idx_in  = r_win ? rchild[IW-1:0] : lchild[IW-1:0];
         end
      end
   end

   // twice the median from both tops
   always_comb begin
      if (lo_size_ff > up_size_ff) med_in = {lo_top, 1'b0};
      else if (lo_size_ff != '0) med_in = {lo_top[SW-1], lo_top} + {up_top[SW-1], up_top};
      else med_in = '0;
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (wr_en && wr_lo) lo_mem[wr_addr] <= wr_data;
      if (wr_en && !wr_lo) up_mem[wr_addr] <= wr_data;
      lo_qa_ff <= lo_mem[rd_addr_a];
      lo_qb_ff <= lo_mem[rd_addr_b];
      up_qa_ff <= up_mem[rd_addr_a];
      up_qb_ff <= up_mem[rd_addr_b];
   end

   // heap sizes
   always_ff @(posedge clock) begin
      if (reset) begin
         lo_size_ff <= '0;
         up_size_ff <= '0;
      end else begin
         lo_size_ff <= lo_size_in;
         up_size_ff <= up_size_in;
      end
   end

   // sequencing and result registers
   always_ff @(posedge clock) begin
      heap_ff <= heap_in;
      idx_ff  <= idx_in;
      lim_ff  <= lim_in;
      val_ff  <= val_in;
      if (cmd.load) x_ff <= sample;
      if (cmd.pop_load) pop_top_ff <= q_a;
      if (cmd.tops) ovf_ff <= stat.full;
      if (cmd.form) begin
         med_ff <= med_in;
         cnt_ff <= held[CW-1:0];
      end
   end

   assign median_x2 = med_ff;
   assign count     = 11'(cnt_ff);
   assign overflow  = ovf_ff;
endmodule
`default_nettype wire

// File: rtl/running_median_two_heap_core.sv
// running_median_two_heap_core: top level of the running median block
// depends on rmth_pkg, rmth_if, rmth_ctrl, rmth_dp
`default_nettype none
// usage
// req channel carries one signed sample per beat; rsp channel returns
// median_x2 (twice the median), count and overflow, one beat per sample.
// one sample is in flight at a time: req is ready only while idle, so the
// next req beat is taken the cycle after the rsp beat leaves.
// from the req beat to rsp valid the sample is written at the tail of its
// heap and sifted up; when the heaps fall out of balance, the top of the
// larger heap is popped, its tail sifted down, and the old top is written
// at the tail of the other heap and sifted up, one memory read per level.
// with the default capacity each heap holds at most 512 entries; a
// dropped sample goes straight to forming the result.
// reset clears the heap sizes; heap contents need no clearing.
// when the receiver stalls, the result holds and req stays not ready.
// a full store drops the sample and repeats the current median with
// overflow set.
module running_median_two_heap_core #(
   parameter int CAPACITY     = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   rmth_if.sink     req,
   rmth_if.source   rsp
);
   import rmth_pkg::*;

   cmd_type    cmd;
   status_type stat;
   logic [SAMPLE_WIDTH:0] med;
   logic [10:0]           cnt;
   logic                  ovf;

   rmth_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .stat(stat), .cmd(cmd)
   );

   rmth_dp #(.CAPACITY(CAPACITY), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .sample(req.data[SAMPLE_WIDTH-1:0]),
      .median_x2(med), .count(cnt), .overflow(ovf)
   );

   // payload packing: median_x2, count, overflow
   assign rsp.data = {med, cnt, ovf};
endmodule
`default_nettype wire

// File: rtl/rmth_checker.sv
// rmth_checker: port-level checks on the running median block
// depends on running_median_two_heap_core ports
`default_nettype none
module rmth_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);
   // one item at a time: never ready on input while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   // a result persists until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   // no result the cycle after accepting an input
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("result too early");
endmodule

bind running_median_two_heap_core rmth_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
);
`default_nettype wire
